// File: rtl/nma_pkg.sv
// ----------------------------------------------------------------------------
// nma_pkg
// Shared constants, types and sequencer states for the nonzero moving average.
// ----------------------------------------------------------------------------
package nma_pkg;

  localparam int WINDOW_LEN  = 30;
  localparam int SAMPLE_BITS = 12;

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  // WINDOW_LEN * (2^SAMPLE_BITS - 1) < 2^(SAMPLE_BITS + clog2(WINDOW_LEN))
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int STEP_W = $clog2(SUM_W);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]       count_t;
  typedef logic [SUM_W-1:0]       sum_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  rd_en;
    logic  wr_en;
    slot_t addr;
  } win_req_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// File: rtl/nonzero_moving_average.sv
// ----------------------------------------------------------------------------
// nonzero_moving_average
// 30-entry moving average of nonzero samples with a sequential divider.
// ----------------------------------------------------------------------------
// one transaction in flight at a time; a new sample is taken only once the
//   previous result has been loaded into the output register. The quotient
//   comes from the one-bit-per-cycle restoring divider; the empty-window case
//   skips the divider
// reset: synchronous active low; ring reads as all zero, sum, count, slot cleared
module nonzero_moving_average (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [nma_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [nma_pkg::SAMPLE_BITS-1:0] out_average,
  output logic                     out_empty_res
);
  import nma_pkg::*;

  state_t    state_r, state_nxt;
  sample_t   sample_r;
  slot_t     slot_r, slot_nxt;
  sum_t      sum_r, sum_nxt;
  count_t    cnt_r, cnt_nxt;
  logic      empty_r;
  logic      out_valid_r;
  sample_t   out_average_r;
  logic      out_empty_r;

  win_req_t  win_req;
  sample_t   old_sample;
  div_ctl_t  div_ctl;
  div_sts_t  div_sts;
  sum_t      quo;
  logic      out_free;
  logic      out_load;

  nma_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (win_req),
    .wr_data (sample_r),
    .rd_data (old_sample)
  );

  nma_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (sum_r),
    .den   (cnt_r),
    .sts   (div_sts),
    .quo   (quo)
  );

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_START;
      ST_START: state_nxt = (cnt_r == '0) ? ST_DONE : ST_DIV;
      ST_DIV:   if (div_sts.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready       = 1'b0;
    win_req.rd_en  = 1'b0;
    win_req.wr_en  = 1'b0;
    win_req.addr   = slot_r;
    div_ctl.start  = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        win_req.rd_en = in_valid;
      end
      ST_READ:  win_req.wr_en = 1'b1;
      ST_START: div_ctl.start = (cnt_r != '0);
      ST_DIV:   ;
      ST_DONE:  out_load = out_free;
      default:  ;
    endcase
  end

  // window bookkeeping, applied once the oldest entry has been read
  always_comb begin
    sum_nxt  = sum_r - SUM_W'(old_sample) + SUM_W'(sample_r);
    cnt_nxt  = cnt_r - CNT_W'(old_sample != '0) + CNT_W'(sample_r != '0);
    slot_nxt = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_START) begin
      empty_r <= (cnt_r == '0);
    end
    if (out_load) begin
      out_average_r <= empty_r ? '0 : quo[SAMPLE_BITS-1:0];
      out_empty_r   <= empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_READ) begin
        slot_r <= slot_nxt;
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_empty_res = out_empty_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_LEN))
    else $error("nonzero count exceeds window length");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> cnt_r != '0)
    else $error("divider started with zero count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_average == '0)
    else $error("empty result carries nonzero average");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !div_sts.busy)
    else $error("new transaction taken while one is in flight");
`endif

endmodule

// File: rtl/nma_window.sv
// ----------------------------------------------------------------------------
// nma_window
// Sample ring memory with per-entry valid bits; an unwritten entry reads as 0.
// ----------------------------------------------------------------------------
module nma_window (
  input  logic                clk,
  input  logic                rst_n,
  input  nma_pkg::win_req_t   req,
  input  nma_pkg::sample_t    wr_data,
  output nma_pkg::sample_t    rd_data
);
  import nma_pkg::*;

  sample_t                 mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]   valid_r;
  sample_t                 rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/nma_divider.sv
// ----------------------------------------------------------------------------
// nma_divider
// Restoring divider, one quotient bit per cycle, window sum by nonzero count.
// ----------------------------------------------------------------------------
module nma_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  nma_pkg::div_ctl_t ctl,
  input  nma_pkg::sum_t     num,
  input  nma_pkg::count_t   den,
  output nma_pkg::div_sts_t sts,
  output nma_pkg::sum_t     quo
);
  import nma_pkg::*;

  count_t              rem_r, rem_nxt;
  sum_t                quo_r, quo_nxt;
  count_t              den_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r;
  logic                done_r;
  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      diff;
  logic                ge;

  always_comb begin
    shifted = {rem_r, quo_r[SUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = quo_r;

endmodule

// File: sim/tb_nonzero_moving_average.sv
// ----------------------------------------------------------------------------
// tb_nonzero_moving_average
// Drives ADC samples into the nonzero moving average and checks each result
// against a cycle-free prediction of the 30-entry ring, its running sum and
// its count of nonzero entries. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_nonzero_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import nma_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_HOLD    = 30;
  localparam int PAUSE_EVERY  = 600;

  typedef struct packed {
    sample_t average;
    logic    empty;
  } avg_result_t;

  typedef enum {
    SAMPLES_ANY,
    SAMPLES_ZERO,
    SAMPLES_FULL_SCALE,
    SAMPLES_TINY,
    SAMPLES_SPARSE
  } sample_mix_t;

  typedef enum {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_mode_t;

  // tracks the sample ring and holds the averages still owed by the block
  class avg_scoreboard;
    sample_t     ring [WINDOW_LEN];
    slot_t       next_slot;
    sum_t        total;
    count_t      live;
    avg_result_t owed_averages [$];
    int          checked;
    int          empties;
    int          errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      next_slot = '0;
      total     = '0;
      live      = '0;
      checked   = 0;
      empties   = 0;
      errors    = 0;
    endfunction

    function void note_sample(sample_t s);
      sample_t     old;
      avg_result_t r;
      old   = ring[next_slot];
      total = total - sum_t'(old) + sum_t'(s);
      if (old != '0) live--;
      if (s != '0) live++;
      ring[next_slot] = s;
      next_slot = (next_slot == slot_t'(WINDOW_LEN - 1)) ? '0 : next_slot + 1'b1;
      if (live == '0) begin
        r.average = '0;
        r.empty   = 1'b1;
      end else begin
        r.average = sample_t'(int'(total) / int'(live));
        r.empty   = 1'b0;
      end
      owed_averages.push_back(r);
    endfunction

    function void check_average(sample_t average, logic empty);
      avg_result_t want;
      if (owed_averages.size() == 0) begin
        $display("%0t: result with nothing pending: average %0d empty %0b",
                 $time, average, empty);
        errors++;
        return;
      end
      want = owed_averages.pop_front();
      checked++;
      if (want.empty) empties++;
      if (average !== want.average) begin
        $display("%0t: average mismatch: expected %0d actual %0d",
                 $time, want.average, average);
        errors++;
      end
      if (empty !== want.empty) begin
        $display("%0t: empty_res mismatch: expected %0b actual %0b",
                 $time, want.empty, empty);
        errors++;
      end
    endfunction

    function int pending();
      return owed_averages.size();
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  sample_t in_sample;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_average;
  logic    out_empty_res;

  avg_scoreboard board;
  int          cycle_count = 0;
  int          samples_sent = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  nonzero_moving_average dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_average   (out_average),
    .out_empty_res (out_empty_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results pending", $time, board.pending());
      $display("tb_nonzero_moving_average: errors");
      $finish;
    end
  end

  // receiver stall pattern, switching to a random ready mode whenever its hold count runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      READY_RARELY: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= ((stall_left % 16) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_average(out_average, out_empty_res);
    end
  end

  // called at a clock edge; returns at the edge that takes the transaction
  task automatic send_sample(input sample_t s);
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    board.note_sample(s);
    samples_sent++;
  endtask

  // sender bursts: a random gap once the current burst runs out
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 24);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (IDLE_HOLD) @(posedge clk);
  endtask

  initial begin
    sample_t     s;
    sample_mix_t mix;
    int          run_len;
    int          random_sent;
    board     = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty window right after reset, full scale, smallest nonzero, bit walk, three fixed values
    send_sample('0);
    pace();
    send_sample('0);
    pace();
    send_sample('1);
    pace();
    send_sample('0);
    pace();
    send_sample(sample_t'(1));
    pace();
    for (int k = 0; k < SAMPLE_BITS; k++) begin
      send_sample(sample_t'(1) << k);
      pace();
    end
    send_sample(sample_t'(4094));
    pace();
    send_sample(sample_t'(2730));
    pace();
    send_sample(sample_t'(1365));
    wait_idle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mix = sample_mix_t'($urandom_range(0, 4));
      // a zero run must outlast the ring to bring it back to empty
      run_len = (mix == SAMPLES_ZERO) ? $urandom_range(WINDOW_LEN, WINDOW_LEN + 10)
                                      : $urandom_range(1, 40);
      repeat (run_len) begin
        case (mix)
          SAMPLES_ZERO:       s = '0;
          SAMPLES_FULL_SCALE: s = '1;
          SAMPLES_TINY:       s = sample_t'($urandom_range(0, 3));
          SAMPLES_SPARSE:     s = ($urandom_range(0, 1) == 0) ? '0 : sample_t'($urandom);
          default:            s = sample_t'($urandom);
        endcase
        send_sample(s);
        random_sent++;
        if (random_sent % PAUSE_EVERY == 0) begin
          wait_idle();
        end else begin
          pace();
        end
      end
    end

    wait_idle();
    $display("sent %0d samples, checked %0d averages, %0d of them on an empty window",
             samples_sent, board.checked, board.empties);
    if (board.errors == 0) begin
      $display("tb_nonzero_moving_average: clean");
    end else begin
      $display("tb_nonzero_moving_average: errors");
    end
    $finish;
  end

endmodule
